@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CHK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mkm_pkg.sv @@
// Shared constants, opcodes and character functions of the keyword matcher.
// No dependencies.
`timescale 1ns / 1ps

package mkm_pkg;

	localparam int DEF_ENTRIES = 128;
	localparam int DEF_MAX_LEN = 32;
	localparam int CHAR_W      = 16;
	localparam int IDX_W       = 7;
	localparam int CAT_W       = 2;
	localparam int MINLEN_W    = 3;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_SCAN   = 2'd2;

	localparam logic [MINLEN_W-1:0] MINLEN_RESET = 3'd3;
	localparam logic [MINLEN_W-1:0] COUNT_MAX    = 3'd7;

	typedef logic [CHAR_W-1:0] char_t;

	// Lower-case A-Z only
	function automatic char_t lower_az(input char_t c);
		if (c >= 16'h0041 && c <= 16'h005A) begin
			return c + 16'h0020;
		end
		return c;
	endfunction

	// Characters removed by normalisation
	function automatic logic is_dropped(input char_t c);
		return (c == 16'h0020) || (c == 16'h005F) || (c == 16'h002D) ||
			(c == 16'h002E) || (c == 16'h002F) || (c == 16'h005C) || (c == 16'h0027);
	endfunction

	// Lower-case, then map look-alike digits to letters
	function automatic char_t norm_char(input char_t c);
		char_t lc;
		lc = lower_az(c);
		unique case (lc)
			16'h0030: return 16'h006F;
			16'h0031: return 16'h006C;
			16'h0033: return 16'h0065;
			16'h0034: return 16'h0061;
			16'h0035: return 16'h0073;
			16'h0037: return 16'h0074;
			default:  return lc;
		endcase
	endfunction

endpackage

@@ rtl/normalized_multi_keyword_matcher_top.sv @@
// Top level of the normalised multi-keyword matcher: control, metadata, windows.
// Depends on mkm_pkg, mkm_pat_mem and mkm_suffix_cmp.
//
// channel  direction  handshake               payload
// command  in         start & !busy           op, entry_index, category, char_code, last
// result   out        result_valid (1 cycle)  hit, hit_entry, hit_category, fuzzy
// config   in         cfg_valid & cfg_ready   cfg_data (min_input_length)
//
// A clear leaves the block idle, an append passes through the append state and a scan
// character walks every entry: the entry walk reads one metadata row and one row of each pattern memory per cycle.
// The result strobe is registered from the scan-done condition of the last character.
// Reset is asynchronous; no clearing pass, the block is ready straight after it.
// The receiver cannot stall; cfg_ready is always high.
`timescale 1ns / 1ps

module normalized_multi_keyword_matcher_top #(
	parameter int ENTRIES = mkm_pkg::DEF_ENTRIES,
	parameter int MAX_LEN = mkm_pkg::DEF_MAX_LEN
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   op,
	input  logic [mkm_pkg::IDX_W-1:0]    entry_index,
	input  logic [mkm_pkg::CAT_W-1:0]    category,
	input  logic [mkm_pkg::CHAR_W-1:0]   char_code,
	input  logic                         last,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [mkm_pkg::MINLEN_W-1:0] cfg_data,
	output logic                         result_valid,
	output logic                         hit,
	output logic [mkm_pkg::IDX_W-1:0]    hit_entry,
	output logic [mkm_pkg::CAT_W-1:0]    hit_category,
	output logic                         fuzzy
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int PW = $clog2(ENTRIES + 1);
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int CW = $clog2(MAX_LEN);
	localparam int RW = MAX_LEN * mkm_pkg::CHAR_W;
	localparam int CTW = mkm_pkg::CAT_W;
	localparam int MW = CTW + 2 * LW;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_APPEND = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;

	logic [1:0] state_q;

	// Latched command
	logic [AW-1:0]               idx_q;
	logic [mkm_pkg::CHAR_W-1:0]  char_q;
	logic                        last_q;
	logic                        norm_push_q;

	// Configuration
	logic [mkm_pkg::MINLEN_W-1:0] min_len_q;

	// Metadata memory {category, raw length, norm length} with valid bits
	logic [MW-1:0]      meta_mem [ENTRIES];
	logic [ENTRIES-1:0] meta_vld_q;
	logic [MW-1:0]      meta_rd_s1;
	logic               meta_rd_vld_s1;
	logic               meta_we;
	logic [AW-1:0]      meta_waddr;
	logic [MW-1:0]      meta_wdata;
	logic [AW-1:0]      raddr;

	// Per-string state
	logic [ENTRIES-1:0]  nfound_q;
	logic [ENTRIES-1:0]  rfound_q;
	logic [RW-1:0]       rwin_q;
	logic [RW-1:0]       nwin_q;
	logic [LW-1:0]       rseen_q;
	logic [LW-1:0]       nseen_q;
	logic [mkm_pkg::MINLEN_W-1:0] count_q;

	// Entry walk
	logic [PW-1:0] ptr_q;
	logic          walk_vld_s1;
	logic [AW-1:0] walk_idx_s1;
	logic          best_vld_q;
	logic [AW-1:0] best_idx_q;
	logic [CTW-1:0] best_cat_q;
	logic          best_fuzzy_q;

	// Pattern memories
	logic [RW-1:0] raw_row_s1;
	logic [RW-1:0] norm_row_s1;
	logic          raw_we;
	logic          norm_we;

	logic          accept;
	logic          idx_ok;
	logic [AW-1:0] in_idx;
	logic          issue;
	logic          scan_done;

	// Decoded metadata of the row read last cycle
	logic [CTW-1:0] rd_cat;
	logic [LW-1:0]  rd_rlen;
	logic [LW-1:0]  rd_nlen;
	logic           raw_match;
	logic           norm_match;
	logic           nfound_new;
	logic           rfound_new;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_idx    = AW'(entry_index);
	assign idx_ok    = (32'(entry_index) < ENTRIES);
	assign issue     = (state_q == ST_SCAN) && (32'(ptr_q) < ENTRIES);
	assign scan_done = (state_q == ST_SCAN) && !issue && !walk_vld_s1;
	assign raddr     = (state_q == ST_IDLE) ? in_idx : ptr_q[AW-1:0];

	always_comb begin
		if (meta_rd_vld_s1) begin
			rd_cat  = meta_rd_s1[MW-1 -: CTW];
			rd_rlen = meta_rd_s1[2*LW-1 -: LW];
			rd_nlen = meta_rd_s1[LW-1:0];
		end else begin
			rd_cat  = '0;
			rd_rlen = '0;
			rd_nlen = '0;
		end
	end

	// Metadata and pattern write port
	always_comb begin
		meta_we    = 1'b0;
		meta_waddr = idx_q;
		meta_wdata = {rd_cat, rd_rlen, rd_nlen};
		raw_we     = 1'b0;
		norm_we    = 1'b0;
		if (accept && op == mkm_pkg::OP_CLEAR && idx_ok) begin
			meta_we    = 1'b1;
			meta_waddr = in_idx;
			meta_wdata = {category, {LW{1'b0}}, {LW{1'b0}}};
		end else if (state_q == ST_APPEND) begin
			raw_we  = (32'(rd_rlen) < MAX_LEN);
			norm_we = !mkm_pkg::is_dropped(char_q) && (32'(rd_nlen) < MAX_LEN);
			meta_we = 1'b1;
			meta_wdata = {rd_cat, rd_rlen + LW'(raw_we), rd_nlen + LW'(norm_we)};
		end
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_waddr] <= meta_wdata;
		end
		meta_rd_s1 <= meta_mem[raddr];
	end

	mkm_pat_mem #(.ENTRIES(ENTRIES), .MAX_LEN(MAX_LEN)) u_raw_mem (
		.clk   (clk),
		.we    (raw_we),
		.waddr (idx_q),
		.lane  (rd_rlen[CW-1:0]),
		.wdata (mkm_pkg::lower_az(char_q)),
		.raddr (raddr),
		.rdata (raw_row_s1)
	);

	mkm_pat_mem #(.ENTRIES(ENTRIES), .MAX_LEN(MAX_LEN)) u_norm_mem (
		.clk   (clk),
		.we    (norm_we),
		.waddr (idx_q),
		.lane  (rd_nlen[CW-1:0]),
		.wdata (mkm_pkg::norm_char(char_q)),
		.raddr (raddr),
		.rdata (norm_row_s1)
	);

	mkm_suffix_cmp #(.MAX_LEN(MAX_LEN)) u_raw_cmp (
		.win   (rwin_q),
		.seen  (rseen_q),
		.pat   (raw_row_s1),
		.len   (rd_rlen),
		.match (raw_match)
	);

	mkm_suffix_cmp #(.MAX_LEN(MAX_LEN)) u_norm_cmp (
		.win   (nwin_q),
		.seen  (nseen_q),
		.pat   (norm_row_s1),
		.len   (rd_nlen),
		.match (norm_match)
	);

	assign rfound_new = rfound_q[walk_idx_s1] || raw_match;
	assign nfound_new = nfound_q[walk_idx_s1] || (norm_push_q && norm_match);

	// Control, windows, flags and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			min_len_q      <= mkm_pkg::MINLEN_RESET;
			meta_vld_q     <= '0;
			meta_rd_vld_s1 <= 1'b0;
			nfound_q       <= '0;
			rfound_q       <= '0;
			rwin_q         <= '0;
			nwin_q         <= '0;
			rseen_q        <= '0;
			nseen_q        <= '0;
			count_q        <= '0;
			ptr_q          <= '0;
			walk_vld_s1    <= 1'b0;
			best_vld_q     <= 1'b0;
			result_valid   <= 1'b0;
		end else begin
			result_valid   <= scan_done && last_q;
			meta_rd_vld_s1 <= meta_vld_q[raddr];
			if (cfg_valid && cfg_ready) begin
				min_len_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q  <= in_idx;
						char_q <= char_code;
						last_q <= last;
						unique case (op)
							mkm_pkg::OP_CLEAR: begin
								if (idx_ok) begin
									meta_vld_q[in_idx] <= 1'b1;
									nfound_q[in_idx]   <= 1'b0;
									rfound_q[in_idx]   <= 1'b0;
								end
							end
							mkm_pkg::OP_APPEND: begin
								if (idx_ok) begin
									state_q <= ST_APPEND;
								end
							end
							mkm_pkg::OP_SCAN: begin
								// push the character into the raw window, and into the normalised window unless it is dropped
								rwin_q <= {mkm_pkg::lower_az(char_code),
									rwin_q[RW-1:mkm_pkg::CHAR_W]};
								if (32'(rseen_q) < MAX_LEN) begin
									rseen_q <= rseen_q + 1'b1;
								end
								norm_push_q <= !mkm_pkg::is_dropped(char_code);
								if (!mkm_pkg::is_dropped(char_code)) begin
									nwin_q <= {mkm_pkg::norm_char(char_code),
										nwin_q[RW-1:mkm_pkg::CHAR_W]};
									if (32'(nseen_q) < MAX_LEN) begin
										nseen_q <= nseen_q + 1'b1;
									end
								end
								if (count_q != mkm_pkg::COUNT_MAX) begin
									count_q <= count_q + 1'b1;
								end
								ptr_q      <= '0;
								best_vld_q <= 1'b0;
								state_q    <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_APPEND: begin
					// the row now holds written metadata
					meta_vld_q[idx_q] <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					walk_vld_s1 <= issue;
					walk_idx_s1 <= ptr_q[AW-1:0];
					if (issue) begin
						ptr_q <= ptr_q + 1'b1;
					end
					// update found flags, keep the lowest normalised hit
					if (walk_vld_s1) begin
						rfound_q[walk_idx_s1] <= rfound_new;
						nfound_q[walk_idx_s1] <= nfound_new;
						if (!best_vld_q && nfound_new && rd_nlen != '0) begin
							best_vld_q   <= 1'b1;
							best_idx_q   <= walk_idx_s1;
							best_cat_q   <= rd_cat;
							best_fuzzy_q <= !rfound_new;
						end
					end
					if (scan_done) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							if (best_vld_q && count_q >= min_len_q && nseen_q != '0) begin
								hit          <= 1'b1;
								hit_entry    <= mkm_pkg::IDX_W'(best_idx_q);
								hit_category <= best_cat_q;
								fuzzy        <= best_fuzzy_q;
							end else begin
								hit          <= 1'b0;
								hit_entry    <= '0;
								hit_category <= '0;
								fuzzy        <= 1'b0;
							end
							// drop all per-string state
							nfound_q <= '0;
							rfound_q <= '0;
							rwin_q   <= '0;
							nwin_q   <= '0;
							rseen_q  <= '0;
							nseen_q  <= '0;
							count_q  <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/mkm_pat_mem.sv @@
// Pattern memory: one row per entry, one character lane written at a time.
// Depends on mkm_pkg.
`timescale 1ns / 1ps

module mkm_pat_mem #(
	parameter int ENTRIES = mkm_pkg::DEF_ENTRIES,
	parameter int MAX_LEN = mkm_pkg::DEF_MAX_LEN,
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int CW = $clog2(MAX_LEN),
	localparam int RW = MAX_LEN * mkm_pkg::CHAR_W
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [CW-1:0]             lane,
	input  logic [mkm_pkg::CHAR_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [RW-1:0]             rdata
);

	logic [RW-1:0] mem [ENTRIES];

	// Write one lane, read a whole row
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr][lane*mkm_pkg::CHAR_W +: mkm_pkg::CHAR_W] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/mkm_suffix_cmp.sv @@
// Suffix compare of a pattern row against the tail of a character window.
// Depends on mkm_pkg.
`timescale 1ns / 1ps

module mkm_suffix_cmp #(
	parameter int MAX_LEN = mkm_pkg::DEF_MAX_LEN,
	localparam int LW = $clog2(MAX_LEN + 1),
	localparam int RW = MAX_LEN * mkm_pkg::CHAR_W
) (
	input  logic [RW-1:0] win,
	input  logic [LW-1:0] seen,
	input  logic [RW-1:0] pat,
	input  logic [LW-1:0] len,
	output logic          match
);

	logic [LW-1:0]      diff;
	logic [RW-1:0]      tail;
	logic [MAX_LEN-1:0] lane_ok;

	// Align the last len window characters with pattern lane 0
	always_comb begin
		diff = LW'(MAX_LEN) - len;
		tail = win >> {diff, 4'b0000};
		for (int k = 0; k < MAX_LEN; k++) begin
			lane_ok[k] = (LW'(k) >= len) ||
				(tail[k*mkm_pkg::CHAR_W +: mkm_pkg::CHAR_W] ==
				 pat[k*mkm_pkg::CHAR_W +: mkm_pkg::CHAR_W]);
		end
		match = (len != '0) && (seen >= len) && (&lane_ok);
	end

endmodule

@@ rtl/mkm_checker.sv @@
// Port-level checks of the keyword matcher, bound to the top level.
// Depends on mkm_pkg, assert_macros.svh and normalized_multi_keyword_matcher_top.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mkm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [1:0]                   op,
	input logic                         result_valid,
	input logic                         hit,
	input logic [mkm_pkg::IDX_W-1:0]    hit_entry,
	input logic [mkm_pkg::CAT_W-1:0]    hit_category,
	input logic                         fuzzy,
	input logic                         cfg_ready
);

	// A result transaction lasts one cycle only
	`CHK_NEXT(a_strobe_single, result_valid, !result_valid, "result strobe held")

	// A miss carries zero fields
	`CHK_NOW(a_miss_zero, result_valid && !hit,
		hit_entry == '0 && hit_category == '0 && !fuzzy, "miss with non-zero fields")

	// A scan transaction always walks the table
	`CHK_NEXT(a_scan_busy, start && !busy && op == mkm_pkg::OP_SCAN, busy,
		"scan accepted without walk")

	// Results appear only once the walk has finished
	`CHK_NOW(a_result_idle, result_valid, !busy, "result while busy")

	// Configuration is always taken
	`CHK_NOW(a_cfg_ready, 1'b1, cfg_ready, "configuration port not ready")

endmodule

bind normalized_multi_keyword_matcher_top mkm_checker u_mkm_checker (.*);

@@ dv/normalized_multi_keyword_matcher_top_test.sv @@
// Self-checking bench for the normalised multi-keyword matcher: loads keyword tables,
// streams strings and compares each reported verdict with an in-bench keyword predictor.
// Depends on mkm_pkg (opcodes, widths) and normalized_multi_keyword_matcher_top.
`timescale 1ns / 1ps

module normalized_multi_keyword_matcher_top_test;

	localparam int NENT = mkm_pkg::DEF_ENTRIES;
	localparam int PLEN = mkm_pkg::DEF_MAX_LEN;
	localparam int IDX_BITS = mkm_pkg::IDX_W;
	localparam int CAT_BITS = mkm_pkg::CAT_W;
	localparam int CHAR_BITS = mkm_pkg::CHAR_W;
	localparam int MIN_BITS = mkm_pkg::MINLEN_W;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0]           op;
		logic [IDX_BITS-1:0]  entry_index;
		logic [CAT_BITS-1:0]  category;
		logic [CHAR_BITS-1:0] char_code;
		logic                 last;
	} command_t;

	typedef struct packed {
		logic                hit;
		logic [IDX_BITS-1:0] hit_entry;
		logic [CAT_BITS-1:0] hit_category;
		logic                fuzzy;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] op = mkm_pkg::OP_CLEAR;
	logic [IDX_BITS-1:0] entry_index = '0;
	logic [CAT_BITS-1:0] category = '0;
	logic [CHAR_BITS-1:0] char_code = '0;
	logic last = 1'b0;
	logic cfg_valid = 1'b0;
	logic [MIN_BITS-1:0] cfg_data = '0;
	logic busy, cfg_ready, result_valid, hit, fuzzy;
	logic [IDX_BITS-1:0] hit_entry;
	logic [CAT_BITS-1:0] hit_category;

	normalized_multi_keyword_matcher_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.entry_index(entry_index), .category(category), .char_code(char_code),
		.last(last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.result_valid(result_valid), .hit(hit), .hit_entry(hit_entry),
		.hit_category(hit_category), .fuzzy(fuzzy)
	);

	always #10 clk = ~clk;

	// Keyword predictor state
	logic [CHAR_BITS-1:0] kw_raw [NENT][PLEN];
	logic [CHAR_BITS-1:0] kw_norm [NENT][PLEN];
	int kw_raw_len [NENT];
	int kw_norm_len [NENT];
	logic [CAT_BITS-1:0] kw_cat [NENT];
	bit seen_norm [NENT];
	bit seen_raw [NENT];
	logic [CHAR_BITS-1:0] raw_hist [PLEN];
	logic [CHAR_BITS-1:0] norm_hist [PLEN];
	int raw_fill, norm_fill, str_chars;
	logic [MIN_BITS-1:0] min_chars;

	command_t pending_cmds[$];
	verdict_t expected_verdicts[$];
	int errors = 0;
	int verdicts_seen = 0;
	int cmds_sent = 0;
	int idle_pct = 0;
	int idle_cycles = 0;
	bit hold_send = 1'b0;

	function automatic logic [CHAR_BITS-1:0] fold_case(logic [CHAR_BITS-1:0] c);
		return (c >= 16'h41 && c <= 16'h5A) ? c + 16'h20 : c;
	endfunction

	function automatic bit is_separator(logic [CHAR_BITS-1:0] c);
		return c == 16'h20 || c == 16'h5F || c == 16'h2D || c == 16'h2E ||
			c == 16'h2F || c == 16'h5C || c == 16'h27;
	endfunction

	function automatic logic [CHAR_BITS-1:0] canon_char(logic [CHAR_BITS-1:0] c);
		logic [CHAR_BITS-1:0] f;
		f = fold_case(c);
		unique case (f)
			16'h30: return 16'h6F;
			16'h31: return 16'h6C;
			16'h33: return 16'h65;
			16'h34: return 16'h61;
			16'h35: return 16'h73;
			16'h37: return 16'h74;
			default: return f;
		endcase
	endfunction

	function automatic void reset_string();
		for (int e = 0; e < NENT; e++) begin
			seen_norm[e] = 0;
			seen_raw[e] = 0;
		end
		for (int k = 0; k < PLEN; k++) begin
			raw_hist[k] = '0;
			norm_hist[k] = '0;
		end
		raw_fill = 0;
		norm_fill = 0;
		str_chars = 0;
	endfunction

	// Append one command to the pending queue
	function automatic void add_cmd(command_t c);
		pending_cmds = {pending_cmds, c};
	endfunction

	// Apply one command to the predictor and queue the verdict that a last scan character causes
	function automatic void predict_command(command_t c);
		int e;
		bit ok;
		verdict_t v;
		unique case (c.op)
			mkm_pkg::OP_CLEAR: begin
				e = int'(c.entry_index);
				kw_raw_len[e] = 0;
				kw_norm_len[e] = 0;
				kw_cat[e] = c.category;
				seen_norm[e] = 0;
				seen_raw[e] = 0;
			end
			mkm_pkg::OP_APPEND: begin
				e = int'(c.entry_index);
				if (kw_raw_len[e] < PLEN) begin
					kw_raw[e][kw_raw_len[e]] = fold_case(c.char_code);
					kw_raw_len[e]++;
				end
				if (!is_separator(c.char_code) && kw_norm_len[e] < PLEN) begin
					kw_norm[e][kw_norm_len[e]] = canon_char(c.char_code);
					kw_norm_len[e]++;
				end
			end
			mkm_pkg::OP_SCAN: begin
				if (str_chars < 7) str_chars++;
				for (int k = 0; k < PLEN - 1; k++) raw_hist[k] = raw_hist[k+1];
				raw_hist[PLEN-1] = fold_case(c.char_code);
				if (raw_fill < PLEN) raw_fill++;
				for (e = 0; e < NENT; e++) begin
					if (kw_raw_len[e] > 0 && raw_fill >= kw_raw_len[e]) begin
						ok = 1;
						for (int k = 0; k < kw_raw_len[e]; k++)
							if (kw_raw[e][k] != raw_hist[PLEN-kw_raw_len[e]+k]) ok = 0;
						if (ok) seen_raw[e] = 1;
					end
				end
				if (!is_separator(c.char_code)) begin
					for (int k = 0; k < PLEN - 1; k++) norm_hist[k] = norm_hist[k+1];
					norm_hist[PLEN-1] = canon_char(c.char_code);
					if (norm_fill < PLEN) norm_fill++;
					for (e = 0; e < NENT; e++) begin
						if (kw_norm_len[e] > 0 && norm_fill >= kw_norm_len[e]) begin
							ok = 1;
							for (int k = 0; k < kw_norm_len[e]; k++)
								if (kw_norm[e][k] != norm_hist[PLEN-kw_norm_len[e]+k]) ok = 0;
							if (ok) seen_norm[e] = 1;
						end
					end
				end
				if (c.last) begin
					v = '0;
					if (str_chars >= int'(min_chars) && norm_fill > 0) begin
						for (e = 0; e < NENT; e++) begin
							if (kw_norm_len[e] > 0 && seen_norm[e]) begin
								v.hit = 1;
								v.hit_entry = IDX_BITS'(e);
								v.hit_category = kw_cat[e];
								v.fuzzy = !seen_raw[e];
								break;
							end
						end
					end
					expected_verdicts = {expected_verdicts, v};
					reset_string();
				end
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// Driver: present queued commands, idling at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_command({op, entry_index, category, char_code, last});
				cmds_sent++;
			end
			if (!(start && busy)) begin
				if (pending_cmds.size() > 0 && !hold_send &&
						$urandom_range(99, 0) >= idle_pct) begin
					command_t c;
					c = pending_cmds.pop_front();
					start <= 1'b1;
					op <= c.op;
					entry_index <= c.entry_index;
					category <= c.category;
					char_code <= c.char_code;
					last <= c.last;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each strobed verdict with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			verdict_t w;
			verdicts_seen++;
			if (expected_verdicts.size() == 0) begin
				report_mismatch("unexpected verdict", verdicts_seen, 0);
			end else begin
				w = expected_verdicts.pop_front();
				if (hit !== w.hit) report_mismatch("hit", int'(hit), int'(w.hit));
				if (hit_entry !== w.hit_entry)
					report_mismatch("hit_entry", int'(hit_entry), int'(w.hit_entry));
				if (hit_category !== w.hit_category)
					report_mismatch("hit_category", int'(hit_category), int'(w.hit_category));
				if (fuzzy !== w.fuzzy) report_mismatch("fuzzy", int'(fuzzy), int'(w.fuzzy));
			end
		end
	end

	// Watchdog: count cycles with no accepted transaction
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired at %0t", $time);
			$display("FAILURE");
			$finish;
		end
	end

	function automatic command_t mk(logic [1:0] o, int idx, int cat, int ch, bit lst);
		command_t c;
		c.op = o;
		c.entry_index = IDX_BITS'(idx);
		c.category = CAT_BITS'(cat);
		c.char_code = CHAR_BITS'(ch);
		c.last = lst;
		return c;
	endfunction

	function automatic logic [CHAR_BITS-1:0] canon_digit();
		case ($urandom_range(5, 0))
			0: return 16'h30;
			1: return 16'h31;
			2: return 16'h33;
			3: return 16'h34;
			4: return 16'h35;
			default: return 16'h37;
		endcase
	endfunction

	function automatic logic [CHAR_BITS-1:0] sep_char();
		case ($urandom_range(6, 0))
			0: return 16'h20;
			1: return 16'h5F;
			2: return 16'h2D;
			3: return 16'h2E;
			4: return 16'h2F;
			5: return 16'h5C;
			default: return 16'h27;
		endcase
	endfunction

	function automatic logic [CHAR_BITS-1:0] pick_char();
		int r;
		r = $urandom_range(99, 0);
		if (r < 50) return CHAR_BITS'(32'h61 + $urandom_range(3, 0));
		if (r < 60) return CHAR_BITS'(32'h41 + $urandom_range(3, 0));
		if (r < 75) return canon_digit();
		if (r < 85) return sep_char();
		return CHAR_BITS'($urandom);
	endfunction

	// Load a keyword: clear then append its characters
	task automatic queue_keyword(int idx, int cat, int len, output int n);
		add_cmd(mk(mkm_pkg::OP_CLEAR, idx, cat, 0, $urandom_range(1, 0) != 0));
		for (int k = 0; k < len; k++)
			add_cmd(mk(mkm_pkg::OP_APPEND, idx, 0, int'(pick_char()),
				$urandom_range(1, 0) != 0));
		n = len + 1;
	endtask

	task automatic queue_string(int len, output int n);
		for (int k = 0; k < len; k++)
			add_cmd(mk(mkm_pkg::OP_SCAN, int'($urandom), int'($urandom), int'(pick_char()),
				k == len - 1));
		n = len;
	endtask

	task automatic drain();
		wait (pending_cmds.size() == 0);
		@(posedge clk);
		while (start || busy || expected_verdicts.size() != 0) @(posedge clk);
		repeat (NENT + 10) @(posedge clk);
	endtask

	task automatic write_min_len(logic [MIN_BITS-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		min_chars = v;
	endtask

	initial begin
		int n, total, mode, lens;
		string s;
		for (int e = 0; e < NENT; e++) begin
			kw_raw_len[e] = 0;
			kw_norm_len[e] = 0;
			kw_cat[e] = '0;
		end
		reset_string();
		min_chars = mkm_pkg::MINLEN_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: keyword "L3_3t" in entry 5, fuzzy leet matches, short strings
		add_cmd(mk(mkm_pkg::OP_CLEAR, 5, 3, 0, 1));
		s = "L3_3t";
		foreach (s[k]) add_cmd(mk(mkm_pkg::OP_APPEND, 5, 0, int'(s[k]), 0));
		add_cmd(mk(mkm_pkg::OP_CLEAR, 127, 2, 16'hFFFF, 0));
		add_cmd(mk(mkm_pkg::OP_APPEND, 127, 1, 16'hFFFF, 1));
		add_cmd(mk(mkm_pkg::OP_CLEAR, 0, 1, 0, 0));
		add_cmd(mk(mkm_pkg::OP_APPEND, 0, 0, 16'h2D, 0));
		add_cmd(mk(OP_SPARE, 127, 3, 16'hFFFF, 1));
		s = "xL33T";
		foreach (s[k]) add_cmd(mk(mkm_pkg::OP_SCAN, 0, 0, int'(s[k]), k == s.len() - 1));
		s = "le-et";
		foreach (s[k]) add_cmd(mk(mkm_pkg::OP_SCAN, 0, 0, int'(s[k]), k == s.len() - 1));
		add_cmd(mk(mkm_pkg::OP_SCAN, 0, 0, 16'hFFFF, 1));
		add_cmd(mk(mkm_pkg::OP_SCAN, 0, 0, 16'h2E, 0));
		add_cmd(mk(mkm_pkg::OP_SCAN, 0, 0, 16'h2E, 0));
		add_cmd(mk(mkm_pkg::OP_SCAN, 0, 0, 16'h2F, 1));
		drain();

		// Random phases: each sets a length limit and an idle rate, reloads some keywords
		total = 0;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_min_len(3'd0);
				1: write_min_len(mkm_pkg::COUNT_MAX);
				default: write_min_len(MIN_BITS'($urandom_range(7, 0)));
			endcase
			mode = ph % 4;
			idle_pct = (mode == 1 || mode == 3) ? 75 : (mode == 2 ? 20 : 0);
			n = 0;
			while (n < 110) begin
				if ($urandom_range(3, 0) == 0) begin
					// half the keywords sit in entries 0 to 7, the rest anywhere; a rare one is long
					lens = ($urandom_range(19, 0) == 0) ? $urandom_range(40, 30)
						: $urandom_range(4, 1);
					queue_keyword($urandom_range(1, 0) ? $urandom_range(7, 0)
						: $urandom_range(127, 0), int'($urandom), lens, lens);
				end else if ($urandom_range(9, 0) == 0) begin
					add_cmd(mk(OP_SPARE, int'($urandom), int'($urandom), int'($urandom), 1));
					lens = 0;
				end else begin
					queue_string($urandom_range(9, 1), lens);
				end
				n += lens;
			end
			total += n;
			if (ph == 4) begin
				// hold the sender until every verdict has come back
				wait (pending_cmds.size() == 0);
				hold_send = 1'b1;
				while (start || busy || expected_verdicts.size() != 0) @(posedge clk);
				hold_send = 1'b0;
			end
			drain();
		end

		$display("covered %0d commands and %0d verdicts across eight length and idle settings",
			cmds_sent, verdicts_seen);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
